/* rtl/core/dynamic_max_manhattan_distance_assert.svh */
// assertion macros shared by the max manhattan distance block
// depends on nothing; included by the modules that check their own logic
`ifndef DYNAMIC_MAX_MANHATTAN_DISTANCE_ASSERT_SVH
`define DYNAMIC_MAX_MANHATTAN_DISTANCE_ASSERT_SVH

// same-cycle implication, held off during reset
`define DMMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DMMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dmmd_pkg.sv */
// shared types, constants and helper functions for the max manhattan distance block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dmmd_pkg;

    localparam int DIMENSIONS  = 3;
    localparam int CAPACITY    = 64;
    localparam int COORD_WIDTH = 16;

    localparam int FIELD_W   = 16;
    localparam int IN_COORDS = 3;
    localparam int IN_W      = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int NUM_MASKS = 1 << (DIMENSIONS - 1);
    localparam int MASK_W    = (DIMENSIONS > 1) ? DIMENSIONS - 1 : 1;
    localparam int SUM_W     = COORD_WIDTH + $clog2(DIMENSIONS) + 1;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int WORD_W    = DIMENSIONS * COORD_WIDTH;
    localparam int DIST_W    = 18;
    localparam int OCNT_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RSVD      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_COMMIT,
        S_REDUCE
    } t_state;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
        logic reduce;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic out_free;
    } t_stat;

    // low bits of a field, sign extended to the coordinate width
    function automatic t_coord to_coord(logic [FIELD_W-1:0] raw);
        logic signed [IN_W-1:0] v;
        v = raw[IN_W-1:0];
        return t_coord'(v);
    endfunction

    function automatic t_coord word_coord(logic [WORD_W-1:0] w, int d);
        return t_coord'(w[d*COORD_WIDTH +: COORD_WIDTH]);
    endfunction

    // c0 +/- c1 +/- ..., mask bit d-1 set means +cd
    function automatic t_sum mask_sum(logic [WORD_W-1:0] w, logic [MASK_W-1:0] m);
        t_sum s;
        s = t_sum'(word_coord(w, 0));
        for (int d = 1; d < DIMENSIONS; d++) begin
            if (m[d-1]) begin
                s = s + t_sum'(word_coord(w, d));
            end else begin
                s = s - t_sum'(word_coord(w, d));
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dmmd_ctrl.sv */
// sequencer for the max manhattan distance block
// depends on dmmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dmmd_ctrl
    import dmmd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    output logic       o_req_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_req_valid) n_state = S_SCAN;
            S_SCAN:   if (i_stat.last_addr) n_state = S_FLUSH;
            S_FLUSH:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_REDUCE;
            S_REDUCE: if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.start = i_req_valid;
            end
            S_SCAN:   o_cmd.issue  = 1'b1;
            S_FLUSH:  o_cmd        = '0;
            S_COMMIT: o_cmd.commit = 1'b1;
            S_REDUCE: o_cmd.reduce = i_stat.out_free;
            default:  o_cmd        = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/dmmd_dp.sv */
// point store, scan datapath and result register for the max manhattan distance block
// depends on dmmd_pkg and dynamic_max_manhattan_distance_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "dynamic_max_manhattan_distance_assert.svh"

module dmmd_dp
    import dmmd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [FIELD_W-1:0]  i_coord [IN_COORDS],
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [DIST_W-1:0]        o_max_distance,
    output logic [OCNT_W-1:0]        o_point_count,
    output logic                     o_set_empty,
    output logic [1:0]               o_status
);

    logic [WORD_W-1:0] r_mem [CAPACITY];
    logic [WORD_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_addr;

    logic [CAPACITY-1:0] r_valid;
    logic [CNT_W-1:0]    r_count;
    t_opcode             r_op;
    logic [WORD_W-1:0]   r_pt;

    t_sum r_hi [NUM_MASKS];
    t_sum r_lo [NUM_MASKS];
    logic r_seen;
    logic r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic r_match_found;
    logic [IDX_W-1:0] r_match_idx;

    logic              r_out_vld;
    logic [DIST_W-1:0] r_out_dist;
    logic [CNT_W-1:0]  r_out_cnt;
    t_status           r_out_stat;
    t_status           r_pend_stat;
    t_status           n_stat;

    logic [WORD_W-1:0] n_pt;
    logic              e_valid;
    logic              e_match;
    logic              e_incl;
    logic [SUM_W:0]    n_best;
    logic [SUM_W:0]    lane_diff;

    always_comb begin
        n_pt = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            if (d < IN_COORDS) begin
                n_pt[d*COORD_WIDTH +: COORD_WIDTH] = to_coord(i_coord[d]);
            end
        end
    end

    // per-entry decision for the word coming out of the store
    always_comb begin
        e_valid = r_valid[r_rd_idx];
        e_match = e_valid && (r_op == OP_ERASE) && (r_rd_data == r_pt);
        e_incl  = e_valid && (r_op != OP_CLEAR) && !(e_match && !r_match_found);
    end

    assign o_stat.last_addr = (r_addr == IDX_W'(CAPACITY - 1));
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_op == OP_INSERT) && (r_count < CNT_W'(CAPACITY))) begin
            r_mem[r_free_idx] <= r_pt;
        end
        r_rd_data <= r_mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_addr    <= '0;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (i_cmd.commit) begin
                case (r_op)
                    OP_INSERT: if (r_count < CNT_W'(CAPACITY)) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_count <= r_count + CNT_W'(1);
                    end
                    OP_ERASE: if (r_match_found) begin
                        r_valid[r_match_idx] <= 1'b0;
                        r_count <= r_count - CNT_W'(1);
                    end
                    OP_CLEAR: begin
                        r_valid <= '0;
                        r_count <= '0;
                    end
                    default: r_count <= r_count;
                endcase
            end
            if (i_cmd.reduce) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op          <= t_opcode'(i_opcode);
            r_pt          <= n_pt;
            r_seen        <= (t_opcode'(i_opcode) == OP_INSERT) && (r_count < CNT_W'(CAPACITY));
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_free_idx    <= '0;
            r_match_idx   <= '0;
            for (int m = 0; m < NUM_MASKS; m++) begin
                r_hi[m] <= mask_sum(n_pt, MASK_W'(m));
                r_lo[m] <= mask_sum(n_pt, MASK_W'(m));
            end
        end else if (r_rd_vld) begin
            if (!e_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (e_match && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_rd_idx;
            end
            if (e_incl) begin
                r_seen <= 1'b1;
                for (int m = 0; m < NUM_MASKS; m++) begin
                    if (!r_seen || mask_sum(r_rd_data, MASK_W'(m)) > r_hi[m]) begin
                        r_hi[m] <= mask_sum(r_rd_data, MASK_W'(m));
                    end
                    if (!r_seen || mask_sum(r_rd_data, MASK_W'(m)) < r_lo[m]) begin
                        r_lo[m] <= mask_sum(r_rd_data, MASK_W'(m));
                    end
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            OP_INSERT: n_stat = (r_count < CNT_W'(CAPACITY)) ? STAT_DONE : STAT_FULL;
            OP_ERASE:  n_stat = r_match_found ? STAT_DONE : STAT_NOT_FOUND;
            default:   n_stat = STAT_DONE;
        endcase
    end

    // widest spread over the sign masks
    always_comb begin
        n_best    = '0;
        lane_diff = '0;
        for (int m = 0; m < NUM_MASKS; m++) begin
            lane_diff = {r_hi[m][SUM_W-1], r_hi[m]} - {r_lo[m][SUM_W-1], r_lo[m]};
            if (lane_diff > n_best) begin
                n_best = lane_diff;
            end
        end
        if (!r_seen) begin
            n_best = '0;
        end
    end

    // status is taken before commit moves the count; the result is held until taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pend_stat <= n_stat;
        end
        if (i_cmd.reduce) begin
            r_out_dist <= DIST_W'(n_best);
            r_out_stat <= r_pend_stat;
            r_out_cnt  <= r_count;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_max_distance = r_out_dist;
    assign o_point_count  = OCNT_W'(r_out_cnt);
    assign o_set_empty    = (r_out_cnt == '0);
    assign o_status       = r_out_stat;

    `DMMD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "count over capacity")
    `DMMD_ASSERT_NOW(a_count_marks, i_clk, i_rst_n, 1'b1, $countones(r_valid) == int'(r_count), "count differs from valid marks")
    `DMMD_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.commit && (r_op == OP_CLEAR), (r_count == '0) && (r_valid == '0), "clear left points")
    `DMMD_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, r_out_vld && o_set_empty, r_out_dist == '0, "empty set with nonzero distance")

endmodule

`default_nettype wire

/* rtl/core/dynamic_max_manhattan_distance.sv */
// top level of the dynamic max manhattan distance block
// depends on dmmd_pkg, dmmd_ctrl and dmmd_dp
`timescale 1ns / 1ps
`default_nettype none

// keeps a multiset of up to 64 three-dimensional signed points and, after each request
// (insert, erase one copy, clear, no-op), returns the largest manhattan distance between stored
// points along with the count, an empty flag and a status code. one request is taken at a
// time: a single read port walks the whole point store once to find the free slot, the
// erase match and the per-mask min and max sums, then the block settles, commits, reduces
// and returns to idle.
// the next request is accepted as soon as the block is back in idle, even while the result
// still waits; a result still waiting when the next one is ready holds the block in reduce.
// the store needs no clearing pass after reset; only its valid marks are reset.

module dynamic_max_manhattan_distance
    import dmmd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request: opcode[1:0], coord_0[17:2], coord_1[33:18], coord_2[49:34], zero fill
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,
    // result: max_distance[17:0], point_count[24:18], set_empty[25], status[27:26], zero fill
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata
);

    t_cmd  cmd;
    t_stat stat;

    logic [FIELD_W-1:0] req_coord [IN_COORDS];
    logic [DIST_W-1:0]  res_dist;
    logic [OCNT_W-1:0]  res_count;
    logic               res_empty;
    logic [1:0]         res_status;

    // unpack the request fields
    assign req_coord[0] = i_s_tdata[17:2];
    assign req_coord[1] = i_s_tdata[33:18];
    assign req_coord[2] = i_s_tdata[49:34];

    dmmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dmmd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_s_tdata[1:0]),
        .i_coord        (req_coord),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_max_distance (res_dist),
        .o_point_count  (res_count),
        .o_set_empty    (res_empty),
        .o_status       (res_status)
    );

    // pack the result fields, highest first
    assign o_m_tdata = {4'b0, res_status, res_empty, res_count, res_dist};

endmodule

`default_nettype wire

/* tb/tb_dmmd_checker.sv */
// checker for the max manhattan distance block: watches both channels, predicts each result
// depends on dmmd_pkg; instantiated by tb_top beside the block
`timescale 1ns / 1ps

module tb_dmmd_checker
    import dmmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic signed [15:0] pts [CAPACITY][3];
    logic               used [CAPACITY];
    int                 npts;
    logic [31:0]        result_fifo [$];

    function automatic logic [31:0] apply_request(logic [55:0] req);
        logic [1:0]         op;
        logic signed [15:0] c [3];
        int                 slot, st;
        longint             s, hi, lo, best;
        logic               seen;
        op = req[1:0];
        c[0] = req[17:2]; c[1] = req[33:18]; c[2] = req[49:34];
        slot = -1; st = STAT_DONE;
        if (op == OP_INSERT) begin
            for (int e = 0; e < CAPACITY; e++) if (!used[e] && slot < 0) slot = e;
            if (slot < 0) st = STAT_FULL;
            else begin
                for (int d = 0; d < 3; d++) pts[slot][d] = c[d];
                used[slot] = 1; npts++;
            end
        end else if (op == OP_ERASE) begin
            for (int e = 0; e < CAPACITY; e++)
                if (used[e] && slot < 0 && pts[e][0] == c[0] && pts[e][1] == c[1]
                    && pts[e][2] == c[2]) slot = e;
            if (slot < 0) st = STAT_NOT_FOUND;
            else begin
                used[slot] = 0; npts--;
            end
        end else if (op == OP_CLEAR) begin
            for (int e = 0; e < CAPACITY; e++) used[e] = 0;
            npts = 0;
        end
        best = 0;
        for (int m = 0; m < 4; m++) begin
            seen = 0; hi = 0; lo = 0;
            for (int e = 0; e < CAPACITY; e++) if (used[e]) begin
                s = pts[e][0];
                s += m[0] ? longint'(pts[e][1]) : -longint'(pts[e][1]);
                s += m[1] ? longint'(pts[e][2]) : -longint'(pts[e][2]);
                if (!seen) begin hi = s; lo = s; seen = 1; end
                else begin if (s > hi) hi = s; if (s < lo) lo = s; end
            end
            if (seen && hi - lo > best) best = hi - lo;
        end
        return {4'd0, st[1:0], npts == 0, 7'(npts), 18'(best)};
    endfunction

    assign o_pending = result_fifo.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            for (int e = 0; e < CAPACITY; e++) used[e] = 0;
            npts = 0;
            result_fifo.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) result_fifo.push_back(apply_request(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_fifo.pop_front();
                    if (want[17:0] !== i_m_tdata[17:0] || want[24:18] !== i_m_tdata[24:18]
                        || want[25] !== i_m_tdata[25] || want[27:26] !== i_m_tdata[27:26]
                        || i_m_tdata[31:28] !== 4'd0) begin
                        $display("%0t: mismatch dist/cnt/empty/stat exp %0d/%0d/%0d/%0d act %0d/%0d/%0d/%0d",
                            $time, want[17:0], want[24:18], want[25], want[27:26],
                            i_m_tdata[17:0], i_m_tdata[24:18], i_m_tdata[25], i_m_tdata[27:26]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
// testbench top for the max manhattan distance block: stimulus, idling, watchdog, verdict
// depends on dmmd_pkg, dynamic_max_manhattan_distance and tb_dmmd_checker
`timescale 1ns / 1ps

module tb_top;
    import dmmd_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    int          fail_count, pending;
    int          idle_cycles = 0;
    int          sent = 0;

    // points inserted so far, so erases can hit stored entries
    logic [47:0] history [$];

    always #10 i_clk = ~i_clk;

    dynamic_max_manhattan_distance u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata));

    tb_dmmd_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending));

    // mostly short gaps, a few long ones, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // result side stalls at random, independent of the request side
    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 0;
        else if ($urandom_range(0, 9) < 7) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 49) == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    // one request: hold valid until accepted, then an optional gap
    task automatic send_request(t_opcode op, logic [15:0] c0, logic [15:0] c1, logic [15:0] c2);
        int g;
        s_tdata  <= {6'd0, c2, c1, c0, op};
        s_tvalid <= 1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
        if (op == OP_INSERT) history.push_back({c2, c1, c0});
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 7));
            3: return 16'($urandom_range(0, 7)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int          r;
        logic [47:0] p;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty set, extremes, copies, absent erase, unused opcode, clear
        send_request(OP_ERASE, 16'h0, 16'h0, 16'h0);
        send_request(OP_INSERT, 16'h8000, 16'h8000, 16'h8000);
        send_request(OP_INSERT, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(OP_INSERT, 16'h8000, 16'h7fff, 16'h8000);
        send_request(OP_INSERT, 16'h7fff, 16'h8000, 16'h7fff);
        send_request(OP_INSERT, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(OP_ERASE, 16'h7fff, 16'h7fff, 16'h7fff);
        send_request(OP_ERASE, 16'h1234, 16'h7fff, 16'h7fff);
        send_request(OP_NOP, 16'hffff, 16'hffff, 16'hffff);
        send_request(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff);
        send_request(OP_INSERT, 16'h0001, 16'hffff, 16'h0000);
        send_request(OP_ERASE, 16'h0001, 16'hffff, 16'h0000);
        // fill to capacity then overflow
        for (int i = 0; i < 66; i++)
            send_request(OP_INSERT, 16'(i), 16'(-i), 16'(i * 3));
        send_request(OP_ERASE, 16'd5, -16'sd5, 16'd15);
        send_request(OP_INSERT, 16'h8000, 16'h7fff, 16'h0);
        send_request(OP_INSERT, 16'h8000, 16'h7fff, 16'h0);
        send_request(OP_CLEAR, 16'h0, 16'h0, 16'h0);
        history.delete();

        // random: mostly inserts and hitting erases, some misses, clears and unused codes
        for (int i = 0; i < 1520; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_request(OP_INSERT, rand_coord(), rand_coord(), rand_coord());
            else if (r < 80 && history.size() > 0) begin
                p = history[$urandom_range(0, history.size() - 1)];
                send_request(OP_ERASE, p[15:0], p[31:16], p[47:32]);
            end else if (r < 90)
                send_request(OP_ERASE, rand_coord(), rand_coord(), rand_coord());
            else if (r < 95)
                send_request(t_opcode'(2'($urandom_range(2, 3))), 16'($urandom),
                             16'($urandom), 16'($urandom));
            else send_request(OP_INSERT, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        s_tvalid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d requests: inserts, erases hit and missed, clears, unused codes", sent);
        $display("covered empty set, full store overflow and extreme coordinates");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dmmd_pkg.sv
rtl/core/dmmd_ctrl.sv
rtl/core/dmmd_dp.sv
rtl/core/dynamic_max_manhattan_distance.sv
tb/tb_dmmd_checker.sv
tb/tb_top.sv
